/* sv/clws_pkg.sv */
// Shared types, codes, constants and helper functions for the character LCD write sequencer.
package clws_pkg;

    localparam int COUNT_WIDTH = 16;
    localparam int CMP_WIDTH   = 32;
    localparam int CFG_ADDR_W  = 5;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_POWERUP,
        PH_ENABLE,
        PH_SETTLE,
        PH_EXTRA
    } t_phase;

    typedef enum logic [2:0] {
        OP_TICK    = 3'd0,
        OP_INIT    = 3'd1,
        OP_COMMAND = 3'd2,
        OP_DATA    = 3'd3,
        OP_GOTO    = 3'd4,
        OP_CLEAR   = 3'd5
    } t_op;

    localparam logic [2:0] REG_ENABLE_HIGH = 3'd0;
    localparam logic [2:0] REG_SETTLE      = 3'd1;
    localparam logic [2:0] REG_CLEAR_WAIT  = 3'd2;
    localparam logic [2:0] REG_POWERUP     = 3'd3;
    localparam logic [2:0] REG_FIRST_WAKE  = 3'd4;
    localparam logic [2:0] REG_LATER_WAKE  = 3'd5;

    localparam logic RS_COMMAND = 1'b0;
    localparam logic RS_DATA    = 1'b1;
    localparam logic RW_WRITE   = 1'b0;

    localparam logic [3:0] INIT_LAST = 4'd6;

    localparam logic [7:0] CMD_WAKE       = 8'h30;
    localparam logic [7:0] CMD_FUNC_SET   = 8'h38;
    localparam logic [7:0] CMD_DISPLAY_ON = 8'h0C;
    localparam logic [7:0] CMD_CLEAR      = 8'h01;
    localparam logic [7:0] CMD_ENTRY_MODE = 8'h06;
    localparam logic [7:0] CMD_SET_DDRAM  = 8'h80;

    localparam logic [7:0] ROW1_BASE = 8'h00;
    localparam logic [7:0] ROW2_BASE = 8'h40;
    localparam logic [7:0] ROW3_BASE = 8'h14;
    localparam logic [7:0] ROW4_BASE = 8'h54;

    typedef struct packed {
        logic [7:0]  enable_high;
        logic [15:0] settle;
        logic [15:0] clear_wait;
        logic [15:0] powerup_wait;
        logic [15:0] first_wake;
        logic [15:0] later_wake;
    } t_cfg;

    typedef struct packed {
        logic [2:0] operation;
        logic [7:0] value;
        logic [2:0] row;
        logic [7:0] column;
    } t_item;

    // Step 7 behaves as the last one; only the low three bits of the step are used.
    function automatic logic [2:0] init_clamp(input logic [3:0] step);
        logic [2:0] s;
        s = step[2:0];
        if (s > INIT_LAST[2:0]) begin
            s = INIT_LAST[2:0];
        end
        return s;
    endfunction

    function automatic logic [7:0] init_byte(input logic [3:0] step);
        logic [7:0] b;
        case (init_clamp(step))
            3'd0, 3'd1, 3'd2: b = CMD_WAKE;
            3'd3:             b = CMD_FUNC_SET;
            3'd4:             b = CMD_DISPLAY_ON;
            3'd5:             b = CMD_CLEAR;
            default:          b = CMD_ENTRY_MODE;
        endcase
        return b;
    endfunction

    function automatic logic [15:0] init_extra(input logic [3:0] step, input t_cfg cfg);
        logic [15:0] e;
        case (init_clamp(step))
            3'd0:       e = cfg.first_wake;
            3'd1, 3'd2: e = cfg.later_wake;
            3'd5:       e = cfg.clear_wait;
            default:    e = 16'd0;
        endcase
        return e;
    endfunction

    function automatic logic [7:0] goto_addr(input logic [2:0] row, input logic [7:0] column);
        logic [7:0] base;
        case (row)
            3'd2:    base = ROW2_BASE;
            3'd3:    base = ROW3_BASE;
            3'd4:    base = ROW4_BASE;
            default: base = ROW1_BASE;
        endcase
        return CMD_SET_DDRAM | 8'(base + column - 8'd1);
    endfunction

endpackage

/* sv/char_lcd_write_sequencer_unit.sv */
// An accepted item passes through the input register, then the result register.
// Throughput: one item per cycle while the output is not stalled; the core's state update per item sets that figure.
// The input register takes a new item while a finished result waits behind a stalled output.
// Reset (synchronous, active low) returns the sequencer to idle with a cleared bus and loads
// the default timing registers.
module char_lcd_write_sequencer_unit (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic [2:0]                      i_operation,
    input  logic [7:0]                      i_value,
    input  logic [2:0]                      i_row,
    input  logic [7:0]                      i_column,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic                            o_reg_select,
    output logic                            o_read_write,
    output logic                            o_enable,
    output logic [7:0]                      o_data_bus,
    output logic                            o_busy_res,
    output logic                            o_rejected,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [clws_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready
);
    import clws_pkg::*;

    t_cfg  cfg;
    t_item r_item;
    logic  r_in_valid;
    logic  out_free;
    logic  core_fire;
    logic  in_load;

    assign out_free   = !o_out_valid || !i_out_stall;
    assign core_fire  = r_in_valid && out_free;
    assign o_in_stall = r_in_valid && !out_free;
    assign in_load    = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_load) begin
            r_in_valid <= 1'b1;
        end else if (core_fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_load) begin
            r_item.operation <= i_operation;
            r_item.value     <= i_value;
            r_item.row       <= i_row;
            r_item.column    <= i_column;
        end
    end

    clws_cfg_regs u_cfg_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    clws_core u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_fire       (core_fire),
        .i_item       (r_item),
        .i_cfg        (cfg),
        .i_out_stall  (i_out_stall),
        .o_out_valid  (o_out_valid),
        .o_reg_select (o_reg_select),
        .o_read_write (o_read_write),
        .o_enable     (o_enable),
        .o_data_bus   (o_data_bus),
        .o_busy_res   (o_busy_res),
        .o_rejected   (o_rejected)
    );

    // A rejected request leaves the sequence running, so the block must still report busy.
    a_reject_implies_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rejected |-> o_busy_res)
        else $error("rejected request reported while the sequencer is idle");

    // The enable strobe is only ever high inside a byte, never while idle.
    a_enable_implies_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_enable |-> o_busy_res)
        else $error("enable strobe high while the sequencer is idle");

    // The input side only stalls when it holds an item that cannot move on.
    a_stall_has_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_in_valid && o_out_valid && i_out_stall))
        else $error("input stalled without a blocked item");

endmodule

/* sv/clws_cfg_regs.sv */
// Configuration register file with an APB-style write and read port.
module clws_cfg_regs (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [clws_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready,
    output clws_pkg::t_cfg                  o_cfg
);
    import clws_pkg::*;

    t_cfg       r_cfg;
    logic       wr_en;
    logic [2:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[CFG_ADDR_W-1:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.enable_high  <= 8'd2;
            r_cfg.settle       <= 16'd50;
            r_cfg.clear_wait   <= 16'd2000;
            r_cfg.powerup_wait <= 16'd50000;
            r_cfg.first_wake   <= 16'd5000;
            r_cfg.later_wake   <= 16'd150;
        end else if (wr_en) begin
            case (reg_idx)
                REG_ENABLE_HIGH: r_cfg.enable_high  <= pwdata[7:0];
                REG_SETTLE:      r_cfg.settle       <= pwdata[15:0];
                REG_CLEAR_WAIT:  r_cfg.clear_wait   <= pwdata[15:0];
                REG_POWERUP:     r_cfg.powerup_wait <= pwdata[15:0];
                REG_FIRST_WAKE:  r_cfg.first_wake   <= pwdata[15:0];
                REG_LATER_WAKE:  r_cfg.later_wake   <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_ENABLE_HIGH: prdata = {24'd0, r_cfg.enable_high};
            REG_SETTLE:      prdata = {16'd0, r_cfg.settle};
            REG_CLEAR_WAIT:  prdata = {16'd0, r_cfg.clear_wait};
            REG_POWERUP:     prdata = {16'd0, r_cfg.powerup_wait};
            REG_FIRST_WAKE:  prdata = {16'd0, r_cfg.first_wake};
            REG_LATER_WAKE:  prdata = {16'd0, r_cfg.later_wake};
            default:         prdata = 32'd0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

/* sv/clws_core.sv */
// Sequencer state machine: applies one registered item per cycle while i_fire is high and holds the result register.
module clws_core (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_fire,
    input  clws_pkg::t_item i_item,
    input  clws_pkg::t_cfg  i_cfg,
    input  logic            i_out_stall,
    output logic            o_out_valid,
    output logic            o_reg_select,
    output logic            o_read_write,
    output logic            o_enable,
    output logic [7:0]      o_data_bus,
    output logic            o_busy_res,
    output logic            o_rejected
);
    import clws_pkg::*;

    t_phase                 r_phase,  n_phase;
    logic [3:0]             r_step,   n_step;
    logic                   r_in_init, n_in_init;
    logic [COUNT_WIDTH-1:0] r_tick,   n_tick;
    logic [15:0]            r_extra,  n_extra;
    logic [7:0]             r_bus,    n_bus;
    logic                   r_select, n_select;
    logic                   r_strobe, n_strobe;
    logic                   r_rejected, n_rejected;
    logic                   r_out_valid, n_out_valid;

    // Next-state logic for one item.
    always_comb begin
        logic [COUNT_WIDTH-1:0] inc;
        logic [CMP_WIDTH-1:0]   inc_w;
        logic                   do_start;
        logic                   do_finish;
        logic                   start_init;
        logic [3:0]             init_sel;
        logic                   st_rs;
        logic [7:0]             st_byte;
        logic [15:0]            st_extra;

        n_phase    = r_phase;
        n_step     = r_step;
        n_in_init  = r_in_init;
        n_tick     = r_tick;
        n_extra    = r_extra;
        n_bus      = r_bus;
        n_select   = r_select;
        n_strobe   = r_strobe;
        n_rejected = r_rejected;
        inc        = r_tick + COUNT_WIDTH'(1);
        inc_w      = CMP_WIDTH'(inc);
        do_start   = 1'b0;
        do_finish  = 1'b0;
        start_init = 1'b0;
        init_sel   = 4'd0;
        st_rs      = RS_COMMAND;
        st_byte    = 8'd0;
        st_extra   = 16'd0;

        if (i_fire) begin
            n_rejected = 1'b0;
            case (i_item.operation)
                OP_TICK: begin
                    case (r_phase)
                        PH_POWERUP: begin
                            n_tick = inc;
                            if (inc_w >= CMP_WIDTH'(i_cfg.powerup_wait)) begin
                                n_step     = 4'd0;
                                start_init = 1'b1;
                                init_sel   = 4'd0;
                            end
                        end
                        PH_ENABLE: begin
                            n_tick = inc;
                            if (inc_w >= CMP_WIDTH'(i_cfg.enable_high)) begin
                                n_strobe = 1'b0;
                                n_tick   = '0;
                                n_phase  = PH_SETTLE;
                            end
                        end
                        PH_SETTLE: begin
                            n_tick = inc;
                            if (inc_w >= CMP_WIDTH'(i_cfg.settle)) begin
                                n_tick = '0;
                                if (r_extra == 16'd0) begin
                                    do_finish = 1'b1;
                                end else begin
                                    n_phase = PH_EXTRA;
                                end
                            end
                        end
                        PH_EXTRA: begin
                            n_tick = inc;
                            if (inc_w >= CMP_WIDTH'(r_extra)) begin
                                do_finish = 1'b1;
                            end
                        end
                        default: n_phase = PH_IDLE;
                    endcase
                end
                OP_INIT, OP_COMMAND, OP_DATA, OP_GOTO, OP_CLEAR: begin
                    if (r_phase != PH_IDLE) begin
                        n_rejected = 1'b1;
                    end else begin
                        case (i_item.operation)
                            OP_INIT: begin
                                n_in_init = 1'b1;
                                n_step    = 4'd0;
                                n_tick    = '0;
                                if (i_cfg.powerup_wait == 16'd0) begin
                                    start_init = 1'b1;
                                    init_sel   = 4'd0;
                                end else begin
                                    n_phase = PH_POWERUP;
                                end
                            end
                            OP_COMMAND: begin
                                do_start = 1'b1;
                                st_byte  = i_item.value;
                            end
                            OP_DATA: begin
                                do_start = 1'b1;
                                st_rs    = RS_DATA;
                                st_byte  = i_item.value;
                            end
                            OP_GOTO: begin
                                do_start = 1'b1;
                                st_byte  = goto_addr(i_item.row, i_item.column);
                            end
                            default: begin
                                do_start = 1'b1;
                                st_byte  = CMD_CLEAR;
                                st_extra = i_cfg.clear_wait;
                            end
                        endcase
                    end
                end
                default: ;
            endcase
        end

        // End of a byte: either move on to the next power-up byte or return to idle.
        if (do_finish) begin
            if (r_in_init && (r_step < INIT_LAST)) begin
                n_step     = r_step + 4'd1;
                start_init = 1'b1;
                init_sel   = r_step + 4'd1;
            end else begin
                n_in_init = 1'b0;
                n_step    = 4'd0;
                n_tick    = '0;
                n_phase   = PH_IDLE;
            end
        end

        if (start_init) begin
            do_start = 1'b1;
            st_rs    = RS_COMMAND;
            st_byte  = init_byte(init_sel);
            st_extra = init_extra(init_sel, i_cfg);
        end

        if (do_start) begin
            n_select = st_rs;
            n_bus    = st_byte;
            n_strobe = 1'b1;
            n_extra  = st_extra;
            n_tick   = '0;
            n_phase  = PH_ENABLE;
        end
    end

    always_comb begin
        if (i_fire) begin
            n_out_valid = 1'b1;
        end else if (i_out_stall) begin
            n_out_valid = r_out_valid;
        end else begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_step      <= 4'd0;
            r_in_init   <= 1'b0;
            r_tick      <= '0;
            r_extra     <= 16'd0;
            r_bus       <= 8'd0;
            r_select    <= 1'b0;
            r_strobe    <= 1'b0;
            r_rejected  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_phase     <= n_phase;
            r_step      <= n_step;
            r_in_init   <= n_in_init;
            r_tick      <= n_tick;
            r_extra     <= n_extra;
            r_bus       <= n_bus;
            r_select    <= n_select;
            r_strobe    <= n_strobe;
            r_rejected  <= n_rejected;
            r_out_valid <= n_out_valid;
        end
    end

    // The state only moves when a result is produced, so the state itself is the result.
    always_comb begin
        o_out_valid  = r_out_valid;
        o_reg_select = r_select;
        o_read_write = RW_WRITE;
        o_enable     = r_strobe;
        o_data_bus   = r_bus;
        o_busy_res   = (r_phase != PH_IDLE);
        o_rejected   = r_rejected;
    end

endmodule
